[sv/alds_pkg.sv]
package alds_pkg;

	// character classes handed from the front to the back
	typedef enum logic [3:0] {
		CLS_OTHER  = 4'd0,
		CLS_DELIM  = 4'd1,
		CLS_OPEN   = 4'd2,
		CLS_CLOSE  = 4'd3,
		CLS_DQUOTE = 4'd4,
		CLS_COLON  = 4'd5,
		CLS_SEMI   = 4'd6,
		CLS_BSLASH = 4'd7,
		CLS_EOT    = 4'd8
	} char_class_t;

	typedef enum logic [2:0] {
		V_INSIDE = 3'd0,
		V_BEFORE = 3'd1,
		V_AFTER  = 3'd2,
		V_ERROR  = 3'd3,
		V_EOT    = 3'd4
	} verdict_t;

	// one queue entry with its valid flag
	typedef struct packed {
		logic        valid;
		char_class_t cls;
	} qbeat_t;

	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int LEN_OUT_W = 16;

endpackage

[sv/address_list_delimiter_scanner.sv]
// Splits an address list header into addresses, one character beat in and one
// verdict beat out. Input beats carry the character in s_tdata and the end of
// text flag in s_tuser; each gives one output beat with the verdict in m_tuser
// and the address length in m_tdata. The block sustains one beat per clock
// while m_tready is high: the front classifies the character in the accept
// cycle, a two-entry queue holds the class, and the back updates the quote,
// comment, group, escape and colon state and loads the output register, so a
// result beat passes the queue entry and then the output register. The state
// update of the back sets the rate. The user is to write group_mode through
// cfg_valid/cfg_data only while the stream is idle; the block does not check.
module address_list_delimiter_scanner #(
	parameter int NEST_BITS   = 8,
	parameter int LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	// config write: group_mode
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data,

	// character stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_byte
	input  logic [0:0]  s_tuser,   // end_of_text

	// verdict stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // address_length
	output logic [2:0]  m_tuser    // verdict
);

	logic             group_mode_q;
	alds_pkg::qbeat_t push;
	alds_pkg::qbeat_t head;
	logic             push_ready;
	logic             pop;

	// config always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			group_mode_q <= cfg_data[0];
		end
	end

	// front: classify each character beat
	alds_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_ready (push_ready),
		.push       (push)
	);

	// decoupling queue of character classes
	alds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	// back: scan state and output register
	alds_back #(
		.NEST_BITS   (NEST_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.group_mode (group_mode_q),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

[sv/alds_front.sv]
module alds_front (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // char_byte
	input  logic [0:0]           s_tuser,   // end_of_text
	input  logic                 push_ready,
	output alds_pkg::qbeat_t     push
);

	alds_pkg::char_class_t cls;

	always_comb begin
		if (s_tuser[0]) begin
			cls = alds_pkg::CLS_EOT;
		end else begin
			case (s_tdata)
				alds_pkg::CH_COMMA,
				alds_pkg::CH_CR,
				alds_pkg::CH_LF:     cls = alds_pkg::CLS_DELIM;
				alds_pkg::CH_OPEN:   cls = alds_pkg::CLS_OPEN;
				alds_pkg::CH_CLOSE:  cls = alds_pkg::CLS_CLOSE;
				alds_pkg::CH_DQUOTE: cls = alds_pkg::CLS_DQUOTE;
				alds_pkg::CH_COLON:  cls = alds_pkg::CLS_COLON;
				alds_pkg::CH_SEMI:   cls = alds_pkg::CLS_SEMI;
				alds_pkg::CH_BSLASH: cls = alds_pkg::CLS_BSLASH;
				default:             cls = alds_pkg::CLS_OTHER;
			endcase
		end
	end

	assign s_tready   = push_ready;
	assign push.valid = s_tvalid;
	assign push.cls   = cls;

endmodule

[sv/alds_queue.sv]
module alds_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  alds_pkg::qbeat_t push,
	output logic             push_ready,
	output alds_pkg::qbeat_t head,
	input  logic             pop
);

	localparam int DEPTH = alds_pkg::QUEUE_DEPTH;
	localparam int PW    = alds_pkg::QPTR_W;

	alds_pkg::char_class_t mem_q [DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [PW:0]           count_q;
	logic                  wr;
	logic                  rd;

	assign push_ready = (count_q != (PW+1)'(DEPTH));
	assign wr         = push.valid && push_ready;
	assign rd         = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cls   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= push.cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/alds_back.sv]
module alds_back #(
	parameter int NEST_BITS   = 8,
	parameter int LENGTH_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             group_mode,
	input  alds_pkg::qbeat_t head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // address_length
	output logic [2:0]       m_tuser    // verdict
);

	localparam logic [NEST_BITS-1:0]   NEST_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
	localparam int                     OW       = alds_pkg::LEN_OUT_W;

	logic                   in_quote_q;
	logic [NEST_BITS-1:0]   comment_depth_q;
	logic [NEST_BITS-1:0]   group_depth_q;
	logic                   escape_q;
	logic                   colon_q;
	logic [LENGTH_BITS-1:0] count_q;

	logic                   in_quote_n;
	logic [NEST_BITS-1:0]   comment_depth_n;
	logic [NEST_BITS-1:0]   group_depth_n;
	logic                   escape_n;
	logic                   colon_n;
	logic [LENGTH_BITS-1:0] count_n;

	logic [NEST_BITS-1:0]   gd_eff;
	logic [LENGTH_BITS-1:0] count_inc;
	logic                   grouped;
	logic                   clear;
	alds_pkg::verdict_t     verdict;
	logic [LENGTH_BITS-1:0] len;
	logic [LENGTH_BITS+OW-1:0] len_ext;

	logic                   m_tvalid_q;
	logic [OW-1:0]          len_q;
	alds_pkg::verdict_t     verdict_q;

	assign pop = head.valid && (!m_tvalid_q || m_tready);

	// a pending colon opens a group unless another colon follows
	assign gd_eff = (colon_q && head.cls != alds_pkg::CLS_COLON && group_depth_q != NEST_MAX)
		? group_depth_q + 1'b1 : group_depth_q;
	assign grouped   = group_mode && (gd_eff != '0);
	assign count_inc = (count_q != LEN_MAX) ? count_q + 1'b1 : count_q;

	always_comb begin
		in_quote_n      = in_quote_q;
		comment_depth_n = comment_depth_q;
		group_depth_n   = gd_eff;
		escape_n        = 1'b0;
		colon_n         = 1'b0;
		count_n         = count_inc;
		clear           = 1'b0;
		verdict         = alds_pkg::V_INSIDE;
		len             = count_inc;
		if (head.cls == alds_pkg::CLS_EOT) begin
			clear = 1'b1;
			if (in_quote_q || comment_depth_q != '0 || grouped) begin
				verdict = alds_pkg::V_ERROR;
				len     = '0;
			end else begin
				verdict = alds_pkg::V_EOT;
				len     = count_q;
			end
		end else if (head.cls == alds_pkg::CLS_DELIM && !in_quote_q &&
				comment_depth_q == '0 && !grouped) begin
			clear   = 1'b1;
			verdict = alds_pkg::V_BEFORE;
			len     = count_q;
		end else if (!escape_q) begin
			case (head.cls)
				alds_pkg::CLS_OPEN: begin
					if (!in_quote_q && comment_depth_q != NEST_MAX) begin
						comment_depth_n = comment_depth_q + 1'b1;
					end
				end
				alds_pkg::CLS_CLOSE: begin
					if (!in_quote_q) begin
						if (comment_depth_q == '0) begin
							clear   = 1'b1;
							verdict = alds_pkg::V_ERROR;
							len     = '0;
						end else begin
							comment_depth_n = comment_depth_q - 1'b1;
						end
					end
				end
				alds_pkg::CLS_DQUOTE: begin
					if (comment_depth_q == '0) begin
						in_quote_n = !in_quote_q;
					end
				end
				alds_pkg::CLS_COLON: begin
					if (!in_quote_q && comment_depth_q == '0) begin
						colon_n = 1'b1;
					end
				end
				alds_pkg::CLS_SEMI: begin
					if (!in_quote_q && comment_depth_q == '0) begin
						if (gd_eff == '0) begin
							clear = 1'b1;
							if (group_mode) begin
								verdict = alds_pkg::V_ERROR;
								len     = '0;
							end else begin
								verdict = alds_pkg::V_AFTER;
								len     = count_inc;
							end
						end else begin
							group_depth_n = gd_eff - 1'b1;
						end
					end
				end
				alds_pkg::CLS_BSLASH: escape_n = 1'b1;
				default: escape_n = 1'b0;
			endcase
		end
	end

	assign len_ext = {{OW{1'b0}}, len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q      <= 1'b0;
			comment_depth_q <= '0;
			group_depth_q   <= '0;
			escape_q        <= 1'b0;
			colon_q         <= 1'b0;
			count_q         <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (pop) begin
				if (clear) begin
					in_quote_q      <= 1'b0;
					comment_depth_q <= '0;
					group_depth_q   <= '0;
					escape_q        <= 1'b0;
					colon_q         <= 1'b0;
					count_q         <= '0;
				end else begin
					in_quote_q      <= in_quote_n;
					comment_depth_q <= comment_depth_n;
					group_depth_q   <= group_depth_n;
					escape_q        <= escape_n;
					colon_q         <= colon_n;
					count_q         <= count_n;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict;
			len_q     <= len_ext[OW-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = len_q;
	assign m_tuser  = verdict_q;

endmodule

[tb/sv/testbench.sv]
// tracks the scanner state and holds the verdicts still owed by the block
class scan_scoreboard;

	typedef struct packed {
		alds_pkg::verdict_t verdict;
		logic [15:0]        len;
	} scan_result_t;

	bit           group_mode;
	bit           in_quote;
	bit [7:0]     comment_depth;
	bit [7:0]     group_depth;
	bit           escape_pending;
	bit           colon_pending;
	bit [15:0]    char_count;
	scan_result_t owed[$];
	int           errors;

	function new();
		group_mode = 1'b0;
		errors = 0;
		clear_scan();
	endfunction

	function void clear_scan();
		in_quote = 1'b0;
		comment_depth = '0;
		group_depth = '0;
		escape_pending = 1'b0;
		colon_pending = 1'b0;
		char_count = '0;
	endfunction

	function void set_mode(bit m);
		group_mode = m;
	endfunction

	function int pending();
		return owed.size();
	endfunction

	function bit [15:0] count_plus_one();
		return (char_count != 16'hFFFF) ? char_count + 16'd1 : char_count;
	endfunction

	function void owe(alds_pkg::verdict_t v, logic [15:0] len);
		scan_result_t r;
		r.verdict = v;
		r.len = len;
		owed.push_back(r);
	endfunction

	// one accepted character beat: work out the verdict it must produce
	function void note_char(logic [7:0] c, logic eot);
		bit grouped;
		if (colon_pending && (eot || c != alds_pkg::CH_COLON) && group_depth != 8'hFF)
			group_depth++;
		colon_pending = 1'b0;
		grouped = group_mode && group_depth != 0;

		if (eot) begin
			if (in_quote || comment_depth != 0 || grouped)
				owe(alds_pkg::V_ERROR, 16'd0);
			else
				owe(alds_pkg::V_EOT, char_count);
			clear_scan();
			return;
		end

		if ((c == alds_pkg::CH_COMMA || c == alds_pkg::CH_CR || c == alds_pkg::CH_LF) &&
				!in_quote && comment_depth == 0 && !grouped) begin
			owe(alds_pkg::V_BEFORE, char_count);
			clear_scan();
			return;
		end

		if (escape_pending) begin
			escape_pending = 1'b0;
		end else begin
			if (!in_quote && c == alds_pkg::CH_OPEN) begin
				if (comment_depth != 8'hFF)
					comment_depth++;
			end else if (!in_quote && c == alds_pkg::CH_CLOSE) begin
				if (comment_depth == 0) begin
					owe(alds_pkg::V_ERROR, 16'd0);
					clear_scan();
					return;
				end
				comment_depth--;
			end else if (comment_depth == 0 && c == alds_pkg::CH_DQUOTE) begin
				in_quote = !in_quote;
			end else if (!in_quote && comment_depth == 0 && c == alds_pkg::CH_COLON) begin
				colon_pending = 1'b1;
			end else if (!in_quote && comment_depth == 0 && c == alds_pkg::CH_SEMI) begin
				if (group_depth == 0) begin
					if (group_mode)
						owe(alds_pkg::V_ERROR, 16'd0);
					else
						owe(alds_pkg::V_AFTER, count_plus_one());
					clear_scan();
					return;
				end
				group_depth--;
			end
			escape_pending = (c == alds_pkg::CH_BSLASH);
		end

		char_count = count_plus_one();
		owe(alds_pkg::V_INSIDE, char_count);
	endfunction

	function void check_result(logic [2:0] verdict, logic [15:0] len);
		scan_result_t e;
		if (owed.size() == 0) begin
			$error("verdict beat with nothing owed: verdict %0d address_length %0d",
				verdict, len);
			errors++;
			return;
		end
		e = owed.pop_front();
		if (verdict !== e.verdict) begin
			$error("verdict: expected %0d actual %0d", e.verdict, verdict);
			errors++;
		end
		if (len !== e.len) begin
			$error("address_length: expected %0d actual %0d", e.len, len);
			errors++;
		end
	endfunction

endclass

module testbench;

	localparam int STALL_LIMIT   = 2000;   // cycles with no beat anywhere
	localparam int RANDOM_BEATS  = 640;
	localparam int RANDOM_PHASES = 6;

	typedef struct packed {
		logic [7:0] c;
		logic       eot;
	} char_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // char_byte
	logic [0:0]  s_tuser;   // end_of_text
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // address_length
	logic [2:0]  m_tuser;   // verdict

	scan_scoreboard sb = new();

	// sender burst state and the switch that turns all idling on or off
	int  burst_left = 0;
	bit  idle_on = 1'b1;
	int  idle_cycles = 0;

	// receiver stall pattern
	int  rx_left = 0;
	int  rx_period = 1;
	int  rx_duty = 1;
	int  rx_phase = 0;

	// characters queued up by the random address builder
	char_beat_t script[$];

	address_list_delimiter_scanner u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// receiver: with idling on, ready follows a duty pattern that is re-rolled every so often,
	// sometimes fully open, sometimes with long stalls
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_left = $urandom_range(20, 200);
			case ($urandom_range(0, 3))
				0: begin
					rx_period = 1;
					rx_duty = 1;
				end
				1: begin
					rx_period = $urandom_range(12, 24);
					rx_duty = 1;
				end
				default: begin
					rx_period = $urandom_range(2, 8);
					rx_duty = $urandom_range(1, rx_period - 1);
				end
			endcase
			rx_phase = 0;
		end
		rx_left--;
		rx_phase = (rx_phase + 1) % rx_period;
		m_tready = !idle_on || (rx_phase < rx_duty);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// watchdog: any beat on any channel counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one character beat; valid stays high across a burst, gaps open between bursts
	task automatic send_beat(input logic [7:0] c, input logic eot);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = 0;
			if (idle_on)
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
					: $urandom_range(0, 3);
			burst_left = $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid = 1'b1;
		s_tdata = c;
		s_tuser = eot;
		do @(posedge clk); while (!s_tready);
		sb.note_char(c, eot);
		burst_left--;
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_beat(txt[i], 1'b0);
	endtask

	task automatic send_eot();
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// drop valid and wait until every owed verdict has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// group_mode write, only with the stream drained
	task automatic write_mode(input bit m);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = m;
		do @(posedge clk); while (!cfg_ready);
		sb.set_mode(m);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic void add(input logic [7:0] c, input logic eot = 1'b0);
		char_beat_t b;
		b.c = c;
		b.eot = eot;
		script.push_back(b);
	endfunction

	function automatic logic [7:0] plain_char();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	function automatic void add_word(input int n);
		repeat (n) add(plain_char());
	endfunction

	// content that goes inside quotes or comments: letters, commas, colons, escapes
	function automatic void add_inner(input int n);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: add(alds_pkg::CH_COMMA);
				1: begin
					add(alds_pkg::CH_BSLASH);
					add(8'($urandom_range(0, 255)));
				end
				2: add(alds_pkg::CH_COLON);
				default: add(plain_char());
			endcase
		end
	endfunction

	// one address built from a few segments, a terminator, sometimes broken
	function automatic void build_address();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 5))
				0: add_word($urandom_range(1, 6));
				1: begin
					add(alds_pkg::CH_DQUOTE);
					add_inner($urandom_range(0, 5));
					add(alds_pkg::CH_DQUOTE);
				end
				2: begin
					add(alds_pkg::CH_OPEN);
					add_inner($urandom_range(0, 3));
					if ($urandom_range(0, 2) == 0) begin
						add(alds_pkg::CH_OPEN);
						add_word(1);
						add(alds_pkg::CH_CLOSE);
					end
					add(alds_pkg::CH_CLOSE);
				end
				3: begin
					add("<");
					add_word($urandom_range(1, 4));
					add("@");
					add_word($urandom_range(1, 4));
					add(">");
				end
				4: begin
					// group: name, colon, members split by commas, semicolon
					add_word($urandom_range(1, 3));
					add(alds_pkg::CH_COLON);
					add_word($urandom_range(1, 3));
					repeat ($urandom_range(0, 2)) begin
						add(alds_pkg::CH_COMMA);
						add_word($urandom_range(1, 3));
					end
					add(alds_pkg::CH_SEMI);
				end
				default: begin
					// colon run, only the last one opens a group
					add_word(1);
					repeat ($urandom_range(2, 3)) add(alds_pkg::CH_COLON);
					add_word(1);
					add(alds_pkg::CH_SEMI);
				end
			endcase
		end
		// broken addresses: a stray or missing bracket character
		if ($urandom_range(0, 6) == 0) begin
			case ($urandom_range(0, 4))
				0: add(alds_pkg::CH_CLOSE);
				1: add(alds_pkg::CH_SEMI);
				2: add(alds_pkg::CH_DQUOTE);
				3: add(alds_pkg::CH_OPEN);
				default: add(alds_pkg::CH_COLON);
			endcase
		end
		case ($urandom_range(0, 4))
			0: begin
				add(alds_pkg::CH_CR);
				add(alds_pkg::CH_LF);
			end
			1: add(alds_pkg::CH_LF);
			2: add(8'h00, 1'b1);
			default: add(alds_pkg::CH_COMMA);
		endcase
	endfunction

	function automatic void build_noise();
		repeat ($urandom_range(1, 8))
			add(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
	endfunction

	task automatic play_script(inout int sent);
		char_beat_t b;
		while (script.size() != 0) begin
			b = script.pop_front();
			send_beat(b.c, b.eot);
			sent++;
		end
	endtask

	initial begin
		int sent;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, plain mode
		write_mode(1'b0);
		send_text("a,,");                    // end before comma, then a delimiter run
		send_beat(alds_pkg::CH_CR, 1'b0);
		send_beat(alds_pkg::CH_LF, 1'b0);
		send_text("\"x,y\"(c,(d)),");         // comma hidden by quotes and nested comments
		send_text("\\,");                    // comma ends the address even after a backslash
		send_text("\\))");                   // escaped close paren, then an unmatched one
		send_text("g::x;;");                 // colon run, group close, unmatched semicolon
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_eot();                          // clean end of text
		send_text("\"q");
		send_eot();                          // open quote at end of text
		send_text("(p");
		send_eot();                          // open comment at end of text
		send_text("h:");
		send_eot();                          // pending colon resolved at end of text

		// directed, group mode
		write_mode(1'b1);
		send_text("g:a,b;,");                // comma inside a group does not split
		send_text(";");                      // unmatched semicolon is an error here
		send_text("k:");
		send_eot();                          // group left open at end of text
		send_text("m:n");
		send_beat(alds_pkg::CH_LF, 1'b0);
		send_eot();

		// random addresses in phases across both modes and idling styles
		sent = 0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_mode(ph[0]);
			idle_on = (ph != 2) && (ph != 5);
			while (sent < (ph + 1) * RANDOM_BEATS / RANDOM_PHASES) begin
				if ($urandom_range(0, 9) == 0)
					build_noise();
				else
					build_address();
				play_script(sent);
			end
		end
		idle_on = 1'b1;

		// wind down: nothing owed, then a wait for stray beats
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
